/* hdl/bmcd_pkg.sv */
// shared types and constants for the multi-click detector
// no dependencies; imported by bmcd_core and button_multi_click_detector
package bmcd_pkg;

  localparam int unsigned MS_W      = 16;
  localparam int unsigned BTN_W     = 8;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_EDGE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;

  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd40;
  localparam logic [MS_W-1:0] TIMEOUT_RST  = 16'd200;
  localparam logic [MS_W-1:0] MS_MAX       = 16'hFFFF;

  localparam logic [CNT_W-1:0] TALLY_MAX  = 3'd6;
  localparam logic [CNT_W-1:0] REPORT_MAX = 3'd5;

  typedef struct packed {
    logic             req_type;
    logic [BTN_W-1:0] button_id;
    logic             pressed;
  } item_t;

  typedef struct packed {
    logic [BTN_W-1:0] click_button;
    logic [CNT_W-1:0] click_count;
  } result_t;

endpackage

/* hdl/bmcd_core.sv */
// click state registers and the combinational update for one request
// depends on bmcd_pkg
module bmcd_core import bmcd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  item_t           item,
  input  logic [MS_W-1:0] debounce_ms,
  input  logic [MS_W-1:0] release_timeout_ms,
  output logic            res_valid,
  output result_t         res
);

  logic [MS_W-1:0]  since_press_r, since_press_nxt;
  logic [CNT_W-1:0] tally_r, tally_nxt;
  logic [BTN_W-1:0] button_r, button_nxt;
  logic             armed_r, armed_nxt;
  logic [MS_W-1:0]  left_r, left_nxt;

  always_comb begin
    since_press_nxt    = since_press_r;
    tally_nxt          = tally_r;
    button_nxt         = button_r;
    armed_nxt          = armed_r;
    left_nxt           = left_r;
    res_valid          = 1'b0;
    res.click_button   = button_r;
    res.click_count    = tally_r;
    unique case (item.req_type)
      REQ_TICK: begin
        if (since_press_r != MS_MAX) begin
          since_press_nxt = since_press_r + 1'b1;
        end
        if (armed_r) begin
          if (left_r <= 16'd1) begin
            // timer expiry: report a count of 1 to 5, then clear
            armed_nxt = 1'b0;
            left_nxt  = '0;
            tally_nxt = '0;
            res_valid = (tally_r != '0) && (tally_r <= REPORT_MAX);
          end else begin
            left_nxt = left_r - 1'b1;
          end
        end
      end
      REQ_EDGE: begin
        if (item.pressed) begin
          since_press_nxt = '0;
          if (since_press_r >= debounce_ms) begin
            armed_nxt = 1'b0;
            left_nxt  = '0;
            if (item.button_id == button_r) begin
              if (tally_r < TALLY_MAX) begin
                tally_nxt = tally_r + 1'b1;
              end
            end else begin
              button_nxt = item.button_id;
              tally_nxt  = 3'd1;
            end
          end
        end else begin
          armed_nxt = 1'b1;
          left_nxt  = release_timeout_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_press_r <= '0;
      tally_r       <= '0;
      button_r      <= '0;
      armed_r       <= 1'b0;
      left_r        <= '0;
    end else if (step_en) begin
      since_press_r <= since_press_nxt;
      tally_r       <= tally_nxt;
      button_r      <= button_nxt;
      armed_r       <= armed_nxt;
      left_r        <= left_nxt;
    end
  end

endmodule

/* hdl/button_multi_click_detector.sv */
// path: an accepted request is held in the input register, then the click state
// update writes its result into the output register
// throughput: one request per cycle while the output register is free or being drained
// reset: synchronous active-low; state clears, debounce 40 ms, timeout 200 ms
// top level: config registers, input and output registers; depends on bmcd_pkg, bmcd_core
module button_multi_click_detector import bmcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [BTN_W-1:0]     in_button_id,
  input  logic                 in_pressed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BTN_W-1:0]     out_click_button,
  output logic [CNT_W-1:0]     out_click_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [MS_W-1:0] debounce_r, timeout_r;
  logic            s1_valid_r;
  item_t           s1_item_r;
  logic            out_valid_r;
  result_t         out_res_r;
  logic            advance;
  logic            res_valid;
  result_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEBOUNCE) begin
        debounce_r <= cfg_wdata;
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // request moves on once the output slot is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type  <= in_req_type;
      s1_item_r.button_id <= in_button_id;
      s1_item_r.pressed   <= in_pressed;
    end
  end

  bmcd_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_en            (advance),
    .item               (s1_item_r),
    .debounce_ms        (debounce_r),
    .release_timeout_ms (timeout_r),
    .res_valid          (res_valid),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_click_button = out_res_r.click_button;
  assign out_click_count  = out_res_r.click_count;

endmodule

/* bench/bmcd_checker.sv */
`timescale 1ns / 100ps
// checker for the multi-click detector: tracks config writes, predicts click reports
// from accepted requests and compares them with the result channel; depends on bmcd_pkg
module bmcd_checker import bmcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [BTN_W-1:0]     in_button_id,
  input  logic                 in_pressed,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [BTN_W-1:0]     out_click_button,
  input  logic [CNT_W-1:0]     out_click_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int unsigned          mismatches,
  output int unsigned          n_waiting
);

  // predicted detector state
  logic [MS_W-1:0]  debounce_ms;
  logic [MS_W-1:0]  timeout_ms;
  logic [MS_W-1:0]  since_press;
  logic [MS_W-1:0]  timer_left;
  logic             timer_on;
  logic [CNT_W-1:0] tally;
  logic [BTN_W-1:0] cur_button;

  result_t pending_clicks[$];

  initial begin
    mismatches = 0;
    n_waiting  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("click check at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // applies one request to the predicted state; returns 1 when a report comes out
  function automatic bit advance_clicks(input item_t req, output result_t click);
    bit fired;
    fired = 1'b0;
    click = '0;
    if (req.req_type == REQ_TICK) begin
      if (since_press != MS_MAX) since_press = since_press + 1'b1;
      if (timer_on) begin
        if (timer_left <= 1) begin
          timer_on   = 1'b0;
          timer_left = '0;
          click.click_button = cur_button;
          click.click_count  = tally;
          fired = (tally >= 1) && (tally <= REPORT_MAX);
          tally = '0;
        end else begin
          timer_left = timer_left - 1'b1;
        end
      end
    end else if (req.pressed) begin
      if (since_press < debounce_ms) begin
        // bounce: only restarts the elapsed count
        since_press = '0;
      end else begin
        since_press = '0;
        timer_on    = 1'b0;
        timer_left  = '0;
        if (req.button_id == cur_button) begin
          if (tally < TALLY_MAX) tally = tally + 1'b1;
        end else begin
          cur_button = req.button_id;
          tally      = 3'd1;
        end
      end
    end else begin
      timer_on   = 1'b1;
      timer_left = timeout_ms;
    end
    return fired;
  endfunction

  always @(posedge clk) begin : watch
    item_t   req;
    result_t click;
    result_t want;
    if (!rst_n) begin
      debounce_ms = DEBOUNCE_RST;
      timeout_ms  = TIMEOUT_RST;
      since_press = '0;
      timer_left  = '0;
      timer_on    = 1'b0;
      tally       = '0;
      cur_button  = '0;
      pending_clicks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEBOUNCE) debounce_ms = cfg_wdata;
        else if (cfg_index == CFG_TIMEOUT) timeout_ms = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        req.req_type  = in_req_type;
        req.button_id = in_button_id;
        req.pressed   = in_pressed;
        if (advance_clicks(req, click)) pending_clicks.push_back(click);
      end
      if (out_valid && out_ready) begin
        if (pending_clicks.size() == 0) begin
          report_mismatch($sformatf("unexpected report button %0d count %0d",
                                    out_click_button, out_click_count));
        end else begin
          want = pending_clicks.pop_front();
          if (out_click_button !== want.click_button)
            report_mismatch($sformatf("click_button got %0d want %0d",
                                      out_click_button, want.click_button));
          if (out_click_count !== want.click_count)
            report_mismatch($sformatf("click_count got %0d want %0d",
                                      out_click_count, want.click_count));
        end
      end
    end
    n_waiting <= pending_clicks.size();
  end

endmodule

/* bench/tb_button_multi_click_detector.sv */
`timescale 1ns / 100ps
// top of the multi-click detector bench: clock, reset, request and config stimulus,
// receiver stalls and the verdict; depends on bmcd_pkg, bmcd_checker and the block
module tb_button_multi_click_detector import bmcd_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS    = 90;

  // indexes past the last register, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = REQ_TICK;
  logic [BTN_W-1:0]     in_button_id = '0;
  logic                 in_pressed = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BTN_W-1:0]     out_click_button;
  logic [CNT_W-1:0]     out_click_count;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned n_waiting;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_go = 1'b0;
  logic [MS_W-1:0] deb_now = DEBOUNCE_RST;
  logic [MS_W-1:0] tmo_now = TIMEOUT_RST;
  logic [BTN_W-1:0] last_btn = '0;

  button_multi_click_detector dut (.*);

  bmcd_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 82; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 82; end
      default: begin send_idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  task automatic send_item(input logic kind, input logic [BTN_W-1:0] btn, input logic prs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_button_id <= BTN_W'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_button_id <= btn;
    in_pressed   <= prs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // edge fields on ticks carry noise
  task automatic send_ticks(input int n);
    repeat (n) send_item(REQ_TICK, BTN_W'($urandom), 1'($urandom));
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_timing(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] tmo);
    drain_pending();
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DAT_W'($urandom));
    cfg_we  <= 1'b0;
    deb_now = deb;
    tmo_now = tmo;
  endtask

  // mostly press bursts timed around the debounce window, some raw noise
  task automatic run_click_phase(input int target);
    int sent;
    int presses;
    int hold;
    int gap;
    logic [BTN_W-1:0] btn;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(4))
          0, 1: btn = last_btn;
          2: btn = '0;
          3: btn = '1;
          default: btn = BTN_W'($urandom);
        endcase
        last_btn = btn;
        presses = $urandom_range(1, 7);
        repeat (presses) begin
          hold = $urandom_range(2);
          if ($urandom_range(4) == 0) gap = $urandom_range(deb_now);
          else gap = ((deb_now > hold) ? deb_now - hold : 0) + $urandom_range(1);
          send_ticks(gap);
          send_item(REQ_EDGE, btn, 1'b1);
          send_ticks(hold);
          sent += gap + hold + 1;
          if ($urandom_range(9) != 0) begin
            send_item(REQ_EDGE, btn, 1'b0);
            sent++;
          end
        end
        gap = tmo_now + $urandom_range(2);
        send_ticks(gap);
        sent += gap;
      end else begin
        send_item(1'($urandom), BTN_W'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [MS_W-1:0] deb;
    logic [MS_W-1:0] tmo;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: first press falls inside the debounce window
    set_idle(0);
    send_item(REQ_EDGE, 8'h5A, 1'b1);
    send_ticks(DEBOUNCE_RST);
    send_item(REQ_EDGE, 8'h5A, 1'b1);
    send_item(REQ_EDGE, 8'h5A, 1'b0);
    send_ticks(TIMEOUT_RST);

    // zero debounce, zero timeout acts as one tick
    load_timing('0, '0);
    send_item(REQ_EDGE, '0, 1'b1);
    send_item(REQ_EDGE, '0, 1'b0);
    send_ticks(1);
    // too many presses: tally saturates and nothing is reported
    repeat (7) send_item(REQ_EDGE, '1, 1'b1);
    send_item(REQ_EDGE, '1, 1'b0);
    send_ticks(1);
    repeat (5) send_item(REQ_EDGE, '1, 1'b1);
    send_item(REQ_EDGE, '1, 1'b0);
    send_ticks(1);
    // new button restarts the count
    send_item(REQ_EDGE, 8'd3, 1'b1);
    send_item(REQ_EDGE, 8'd4, 1'b1);
    send_item(REQ_EDGE, 8'd4, 1'b0);
    send_ticks(1);
    // release with empty tally, then a tick carrying edge fields
    send_item(REQ_EDGE, 8'd4, 1'b0);
    send_item(REQ_TICK, '1, 1'b1);
    send_item(REQ_TICK, '0, 1'b0);

    // widest settings: presses inside the long debounce window, long timeout armed
    load_timing('1, '1);
    send_item(REQ_EDGE, 8'h81, 1'b1);
    send_ticks(20);
    send_item(REQ_EDGE, 8'h81, 1'b1);
    send_item(REQ_EDGE, 8'h81, 1'b0);
    send_ticks(20);

    for (int p = 0; p < 8; p++) begin
      set_idle(p % 4);
      deb = (p == 0 || p == 4) ? 0 : $urandom_range(6);
      tmo = deb + $urandom_range(2, 8);
      if (p == 2) tmo = 0;
      if (p == 4 || p == 5) tmo = 1;
      load_timing(deb, tmo);
      if (p == 4) hold_go = 1'b1;
      run_click_phase(PHASE_ITEMS);
    end

    drain_pending();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bmcd_pkg.sv
hdl/bmcd_core.sv
hdl/button_multi_click_detector.sv
bench/bmcd_checker.sv
bench/tb_button_multi_click_detector.sv
